>>> hdl/crt_pkg.sv
// Shared types, codes and helper functions for the cyclic relay timer.
`timescale 1ns / 1ps

package crt_pkg;

    localparam int unsigned MS_W     = 26;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned CLOCK_W  = 11;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [MS_W-1:0]     MS_PER_SECOND = MS_W'(1000);
    localparam logic [HOUR_W-1:0]   LAST_HOUR     = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] LAST_MINUTE   = MINUTE_W'(59);
    localparam logic [CLOCK_W-1:0]  WINDOW_TO_RESET = CLOCK_W'(1531);

    typedef logic [MS_W-1:0]    ms_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CLOCK_W-1:0] clock_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_EVENT = 2'd1,
        CMD_FORCE = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_MANUAL   = 2'd0,
        MODE_SCHEDULE = 2'd1,
        MODE_SCHED_DET = 2'd2,
        MODE_DETECTOR = 2'd3
    } run_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUN_MODE     = 3'd0,
        REG_ACTIVE_LEVEL = 3'd1,
        REG_IDLE_LEVEL   = 3'd2,
        REG_ON_SECONDS   = 3'd3,
        REG_OFF_SECONDS  = 3'd4,
        REG_REPEAT_COUNT = 3'd5,
        REG_WINDOW_FROM  = 3'd6,
        REG_WINDOW_TO    = 3'd7
    } cfg_reg_t;

    // Timer phase, one-hot.
    typedef enum logic [2:0] {
        PH_STOPPED = 3'b001,
        PH_ACTIVE  = 3'b010,
        PH_IDLE    = 3'b100
    } phase_t;

    localparam logic [1:0] PHASE_CODE_STOPPED = 2'd0;
    localparam logic [1:0] PHASE_CODE_ACTIVE  = 2'd1;
    localparam logic [1:0] PHASE_CODE_IDLE    = 2'd2;

    typedef struct packed {
        cmd_t                cmd;
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic                event_level;
        logic                pin_level;
    } item_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_ACTIVE: code = PHASE_CODE_ACTIVE;
            PH_IDLE:   code = PHASE_CODE_IDLE;
            default:   code = PHASE_CODE_STOPPED;
        endcase
        return code;
    endfunction

    // Daily window; end exclusive but 0:00-23:59 is all day; may wrap past midnight.
    function automatic logic in_window(input clock_t from, input clock_t to,
                                       input logic [HOUR_W-1:0] h,
                                       input logic [MINUTE_W-1:0] m);
        logic [HOUR_W-1:0]   fh;
        logic [HOUR_W-1:0]   th;
        logic [MINUTE_W-1:0] fm;
        logic [MINUTE_W-1:0] tm;
        logic                hit;
        fh = from[CLOCK_W-1:MINUTE_W];
        fm = from[MINUTE_W-1:0];
        th = to[CLOCK_W-1:MINUTE_W];
        tm = to[MINUTE_W-1:0];
        if (fh == '0 && fm == '0 && th == LAST_HOUR && tm == LAST_MINUTE) begin
            hit = 1'b1;
        end else if (fh == th) begin
            hit = (fm < tm) && (h == fh) && (fm <= m) && (tm > m);
        end else if (fh < th) begin
            hit = (fh < h && h < th) || (h == fh && fm <= m) || (h == th && tm > m);
        end else begin
            hit = (h == fh && fm <= m) || (h == th && tm > m) ||
                  (h <= LAST_HOUR && h > fh) || (h < th);
        end
        return hit;
    endfunction

endpackage

>>> hdl/cyclic_relay_timer_with_time_window_top.sv
// Top level of the cyclic relay timer with a daily time window.
`timescale 1ns / 1ps

// Each request (tick, detector event, force idle or stop) yields exactly one result. A request
// is held in an input register and the whole timer update, window test included, runs
// combinationally on its way into the result register, so one request per clock is sustained
// while the consumer accepts every result. The input register can still take one request while
// a finished result waits for the consumer. The phase lengths in milliseconds are formed when
// on_seconds and off_seconds are written, so the per-request path holds only a 26-bit decrement
// and compare. Configuration writes are always accepted and must be issued while no request is
// in flight.
module cyclic_relay_timer_with_time_window_top
    import crt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [15:0]           cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [HOUR_W-1:0]     s_hour_now,
    input  logic [MINUTE_W-1:0]   s_minute_now,
    input  logic                  s_event_level,
    input  logic                  s_pin_level,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_drive_written,
    output logic                  m_drive_level,
    output logic [1:0]            m_phase,
    output logic [COUNT_W-1:0]    m_cycles_left
);

    // Configuration registers.
    run_mode_t run_mode_reg;
    logic      active_level_reg;
    logic      idle_level_reg;
    ms_t       on_ms_reg;
    ms_t       off_ms_reg;
    count_t    repeat_count_reg;
    clock_t    window_from_reg;
    clock_t    window_to_reg;

    // Timer state.
    ms_t    remaining_ms_reg, remaining_ms_next;
    phase_t phase_reg, phase_next;
    count_t cycles_reg, cycles_next;
    logic   relay_level_reg, relay_level_next;

    // Pipeline registers.
    logic   in_vld_reg;
    item_t  in_item_reg;
    logic   out_vld_reg;
    logic   out_written_reg;
    logic   out_level_reg;
    logic [1:0] out_phase_reg;
    count_t out_cycles_reg;

    logic   out_free;
    logic   advance;
    logic   s_take;
    logic   window_open;
    logic   wrote;
    logic   det_mode;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_vld_reg || m_ready;
    assign advance   = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || out_free;
    assign s_take    = s_valid && s_ready;

    assign m_valid         = out_vld_reg;
    assign m_drive_written = out_written_reg;
    assign m_drive_level   = out_level_reg;
    assign m_phase         = out_phase_reg;
    assign m_cycles_left   = out_cycles_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_mode_reg     <= MODE_MANUAL;
            active_level_reg <= 1'b1;
            idle_level_reg   <= 1'b0;
            on_ms_reg        <= '0;
            off_ms_reg       <= '0;
            repeat_count_reg <= '0;
            window_from_reg  <= '0;
            window_to_reg    <= WINDOW_TO_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_addr))
                REG_RUN_MODE:     run_mode_reg     <= run_mode_t'(cfg_wdata[1:0]);
                REG_ACTIVE_LEVEL: active_level_reg <= cfg_wdata[0];
                REG_IDLE_LEVEL:   idle_level_reg   <= cfg_wdata[0];
                REG_ON_SECONDS:   on_ms_reg        <= MS_W'(cfg_wdata) * MS_PER_SECOND;
                REG_OFF_SECONDS:  off_ms_reg       <= MS_W'(cfg_wdata) * MS_PER_SECOND;
                REG_REPEAT_COUNT: repeat_count_reg <= cfg_wdata;
                REG_WINDOW_FROM:  window_from_reg  <= cfg_wdata[CLOCK_W-1:0];
                REG_WINDOW_TO:    window_to_reg    <= cfg_wdata[CLOCK_W-1:0];
                default: ;
            endcase
        end
    end

    assign window_open = in_window(window_from_reg, window_to_reg,
                                   in_item_reg.hour_now, in_item_reg.minute_now);
    assign det_mode = (run_mode_reg == MODE_SCHED_DET) || (run_mode_reg == MODE_DETECTOR);

    // Timer update for the request in the input register.
    always_comb begin
        remaining_ms_next = remaining_ms_reg;
        phase_next        = phase_reg;
        cycles_next       = cycles_reg;
        relay_level_next  = relay_level_reg;
        wrote             = 1'b0;
        case (in_item_reg.cmd)
            CMD_TICK: begin
                if (run_mode_reg == MODE_SCHEDULE) begin
                    wrote            = 1'b1;
                    relay_level_next = window_open ? active_level_reg : idle_level_reg;
                end
                if (phase_reg == PH_ACTIVE || phase_reg == PH_IDLE) begin
                    // A count of one or zero reaches zero on this tick.
                    if (remaining_ms_reg > MS_W'(1)) begin
                        remaining_ms_next = remaining_ms_reg - MS_W'(1);
                    end else if (phase_reg == PH_ACTIVE) begin
                        wrote             = 1'b1;
                        relay_level_next  = idle_level_reg;
                        remaining_ms_next = off_ms_reg;
                        phase_next        = PH_IDLE;
                    end else if (cycles_reg != '0) begin
                        wrote             = 1'b1;
                        relay_level_next  = active_level_reg;
                        remaining_ms_next = on_ms_reg;
                        cycles_next       = cycles_reg - COUNT_W'(1);
                        phase_next        = PH_ACTIVE;
                    end else begin
                        remaining_ms_next = '0;
                        phase_next        = PH_STOPPED;
                    end
                end
            end
            CMD_EVENT: begin
                if (window_open && det_mode &&
                    in_item_reg.event_level == active_level_reg) begin
                    cycles_next = repeat_count_reg;
                    if (on_ms_reg != '0 && repeat_count_reg != '0) begin
                        if (in_item_reg.pin_level == active_level_reg) begin
                            wrote             = 1'b1;
                            relay_level_next  = active_level_reg;
                            remaining_ms_next = on_ms_reg;
                            cycles_next       = repeat_count_reg - COUNT_W'(1);
                            phase_next        = PH_ACTIVE;
                        end
                    end else begin
                        // Without timing the relay simply follows the detector pin.
                        wrote            = 1'b1;
                        relay_level_next = (in_item_reg.pin_level == active_level_reg) ?
                                           active_level_reg : idle_level_reg;
                    end
                end
            end
            CMD_FORCE: begin
                wrote            = 1'b1;
                relay_level_next = idle_level_reg;
            end
            CMD_STOP: begin
                phase_next = PH_STOPPED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            remaining_ms_reg <= '0;
            phase_reg        <= PH_STOPPED;
            cycles_reg       <= '0;
            relay_level_reg  <= 1'b0;
        end else begin
            if (s_take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg      <= 1'b1;
                remaining_ms_reg <= remaining_ms_next;
                phase_reg        <= phase_next;
                cycles_reg       <= cycles_next;
                relay_level_reg  <= relay_level_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.cmd         <= cmd_t'(s_cmd);
            in_item_reg.hour_now    <= s_hour_now;
            in_item_reg.minute_now  <= s_minute_now;
            in_item_reg.event_level <= s_event_level;
            in_item_reg.pin_level   <= s_pin_level;
        end
        if (advance) begin
            out_written_reg <= wrote;
            out_level_reg   <= relay_level_next;
            out_phase_reg   <= phase_code(phase_next);
            out_cycles_reg  <= cycles_next;
        end
    end

    // The input side stalls only when both pipeline registers are full and blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled while a pipeline register was free");

    // A stop request yields a stopped phase and no relay drive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.cmd == CMD_STOP) |=>
        (m_valid && m_phase == PHASE_CODE_STOPPED && !m_drive_written))
        else $error("stop request did not stop the timer");

    // A force idle request drives the idle level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.cmd == CMD_FORCE) |=>
        (m_drive_written && m_drive_level == $past(idle_level_reg)))
        else $error("force idle request did not drive the idle level");

    // The reported relay level and cycle count always match the stored timer state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_drive_level == relay_level_reg && m_cycles_left == cycles_reg))
        else $error("result does not match the timer state");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the cyclic relay timer with a daily time window.
`timescale 1ns / 1ps

module tb_top;
    import crt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic         written;
        logic         level;
        logic [1:0]   phase;
        count_t       cycles;
    } relay_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [15:0]          cfg_wdata = '0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_cmd = '0;
    logic [HOUR_W-1:0]    s_hour_now = '0;
    logic [MINUTE_W-1:0]  s_minute_now = '0;
    logic                 s_event_level = 1'b0;
    logic                 s_pin_level = 1'b0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_drive_written;
    logic                 m_drive_level;
    logic [1:0]           m_phase;
    logic [COUNT_W-1:0]   m_cycles_left;

    cyclic_relay_timer_with_time_window_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_hour_now      (s_hour_now),
        .s_minute_now    (s_minute_now),
        .s_event_level   (s_event_level),
        .s_pin_level     (s_pin_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_written (m_drive_written),
        .m_drive_level   (m_drive_level),
        .m_phase         (m_phase),
        .m_cycles_left   (m_cycles_left)
    );

    always #10 aclk = ~aclk;

    // Register copies used by the predictor, at their reset values.
    run_mode_t mode_r   = MODE_MANUAL;
    logic      act_lvl  = 1'b1;
    logic      idle_lvl = 1'b0;
    count_t    on_sec   = '0;
    count_t    off_sec  = '0;
    count_t    rep_cnt  = '0;
    clock_t    win_from = '0;
    clock_t    win_to   = WINDOW_TO_RESET;

    // Timer state of the predictor.
    ms_t        ms_left   = '0;
    logic [1:0] tmr_phase = PHASE_CODE_STOPPED;
    count_t     cyc_left  = '0;
    logic       relay     = 1'b0;
    logic       drove;

    item_t          requests[$];
    relay_result_t  relay_results[$];
    int unsigned    queued_total = 0;
    int unsigned    checked_total = 0;
    int unsigned    faults = 0;
    int unsigned    burst_left = 0;
    int unsigned    gap_left = 0;
    int unsigned    stall_count = 0;
    int unsigned    cycles_run = 0;

    function automatic logic window_open(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m);
        logic [HOUR_W-1:0]   fh;
        logic [HOUR_W-1:0]   th;
        logic [MINUTE_W-1:0] fm;
        logic [MINUTE_W-1:0] tm;
        fh = win_from[CLOCK_W-1:MINUTE_W];
        fm = win_from[MINUTE_W-1:0];
        th = win_to[CLOCK_W-1:MINUTE_W];
        tm = win_to[MINUTE_W-1:0];
        if (fh == 0 && fm == 0 && th == LAST_HOUR && tm == LAST_MINUTE) return 1'b1;
        if (fh == th) return (fm < tm) && (h == fh) && (m >= fm) && (m < tm);
        if (fh < th) begin
            return (h > fh && h < th) || (h == fh && m >= fm) || (h == th && m < tm);
        end
        // The window wraps past midnight.
        return (h == fh && m >= fm) || (h == th && m < tm) ||
               (h > fh && h <= LAST_HOUR) || (h < th);
    endfunction

    task automatic drive_relay(input logic lvl);
        relay = lvl;
        drove = 1'b1;
    endtask

    task automatic begin_on_phase();
        drive_relay(act_lvl);
        ms_left   = ms_t'(on_sec) * MS_PER_SECOND;
        cyc_left  = cyc_left - COUNT_W'(1);
        tmr_phase = PHASE_CODE_ACTIVE;
    endtask

    task automatic predict_relay(input item_t it);
        drove = 1'b0;
        case (it.cmd)
            CMD_TICK: begin
                if (mode_r == MODE_SCHEDULE) begin
                    drive_relay(window_open(it.hour_now, it.minute_now) ? act_lvl : idle_lvl);
                end
                if (tmr_phase == PHASE_CODE_ACTIVE || tmr_phase == PHASE_CODE_IDLE) begin
                    if (ms_left != 0) ms_left = ms_left - MS_W'(1);
                    if (ms_left == 0) begin
                        if (tmr_phase == PHASE_CODE_ACTIVE) begin
                            drive_relay(idle_lvl);
                            ms_left   = ms_t'(off_sec) * MS_PER_SECOND;
                            tmr_phase = PHASE_CODE_IDLE;
                        end else if (cyc_left != 0) begin
                            begin_on_phase();
                        end else begin
                            tmr_phase = PHASE_CODE_STOPPED;
                        end
                    end
                end
            end
            CMD_EVENT: begin
                if (window_open(it.hour_now, it.minute_now) &&
                    (mode_r == MODE_SCHED_DET || mode_r == MODE_DETECTOR) &&
                    it.event_level == act_lvl) begin
                    cyc_left = rep_cnt;
                    if (on_sec != 0 && cyc_left != 0) begin
                        if (it.pin_level == act_lvl) begin_on_phase();
                    end else begin
                        drive_relay((it.pin_level == act_lvl) ? act_lvl : idle_lvl);
                    end
                end
            end
            CMD_FORCE: drive_relay(idle_lvl);
            default:   tmr_phase = PHASE_CODE_STOPPED;
        endcase
        relay_results.push_back({drove, relay, tmr_phase, cyc_left});
    endtask

    // Driver: presents queued requests in bursts separated by random gaps.
    always @(posedge aclk) begin
        item_t took;
        item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                took = '{cmd_t'(s_cmd), s_hour_now, s_minute_now, s_event_level, s_pin_level};
                predict_relay(took);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (requests.size() != 0) begin
                    nxt = requests.pop_front();
                    s_cmd         <= nxt.cmd;
                    s_hour_now    <= nxt.hour_now;
                    s_minute_now  <= nxt.minute_now;
                    s_event_level <= nxt.event_level;
                    s_pin_level   <= nxt.pin_level;
                    s_valid       <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 31);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result in order and stalls on a rotating pattern.
    always @(posedge aclk) begin
        relay_result_t got;
        relay_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_drive_written, m_drive_level, m_phase, m_cycles_left};
                if (relay_results.size() == 0) begin
                    faults++;
                    $display("%0t: result with nothing pending: written=%0d level=%0d phase=%0d cycles=%0d",
                             $time, got.written, got.level, got.phase, got.cycles);
                end else begin
                    want = relay_results.pop_front();
                    checked_total++;
                    if (got !== want) begin
                        faults++;
                        $display("%0t: expected written=%0d level=%0d phase=%0d cycles=%0d, got written=%0d level=%0d phase=%0d cycles=%0d",
                                 $time, want.written, want.level, want.phase, want.cycles,
                                 got.written, got.level, got.phase, got.cycles);
                    end
                end
            end
            stall_count++;
            case (stall_count[9:8])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_ready <= (stall_count[1:0] == 2'd0);
                default: m_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("cyclic_relay_timer_with_time_window_top: mismatch");
            $finish;
        end
    end

    function automatic clock_t hm(input int unsigned h, input int unsigned m);
        return clock_t'(h * 64 + m);
    endfunction

    function automatic clock_t rand_clock();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return (r == 0) ? clock_t'(0) : WINDOW_TO_RESET;
        if (r < 5) return clock_t'($urandom_range(0, 1531));
        return hm($urandom_range(0, 23), $urandom_range(0, 59));
    endfunction

    function automatic item_t mk(input cmd_t c, input int unsigned h, input int unsigned m,
                                 input logic ev, input logic pin);
        item_t it;
        it.cmd         = c;
        it.hour_now    = h[HOUR_W-1:0];
        it.minute_now  = m[MINUTE_W-1:0];
        it.event_level = ev;
        it.pin_level   = pin;
        return it;
    endfunction

    function automatic item_t rand_item(input int unsigned tick_pct);
        item_t       it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            it.cmd = CMD_TICK;
        end else begin
            r = $urandom_range(0, 99);
            it.cmd = (r < 60) ? CMD_EVENT : (r < 85) ? CMD_FORCE : CMD_STOP;
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
            // Take the hour of either window edge and a minute on or next to the minute of either edge.
            it.hour_now = $urandom_range(0, 1) ? win_from[CLOCK_W-1:MINUTE_W]
                                               : win_to[CLOCK_W-1:MINUTE_W];
            it.minute_now = ($urandom_range(0, 1) ? win_from[MINUTE_W-1:0]
                                                  : win_to[MINUTE_W-1:0])
                            + MINUTE_W'($urandom_range(0, 2)) - MINUTE_W'(1);
        end else if (r < 35) begin
            it.hour_now   = HOUR_W'($urandom);
            it.minute_now = MINUTE_W'($urandom);
        end else begin
            it.hour_now   = HOUR_W'($urandom_range(0, 23));
            it.minute_now = MINUTE_W'($urandom_range(0, 59));
        end
        it.event_level = ($urandom_range(0, 3) != 0) ? act_lvl : ~act_lvl;
        it.pin_level   = ($urandom_range(0, 9) < 7) ? act_lvl : ~act_lvl;
        return it;
    endfunction

    task automatic queue_item(input item_t it);
        requests.push_back(it);
        queued_total++;
    endtask

    // Called on a clock edge; leaves the write channel valid for the caller to lower.
    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[15:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RUN_MODE:     mode_r   = run_mode_t'(val[1:0]);
            REG_ACTIVE_LEVEL: act_lvl  = val[0];
            REG_IDLE_LEVEL:   idle_lvl = val[0];
            REG_ON_SECONDS:   on_sec   = val[15:0];
            REG_OFF_SECONDS:  off_sec  = val[15:0];
            REG_REPEAT_COUNT: rep_cnt  = val[15:0];
            REG_WINDOW_FROM:  win_from = val[CLOCK_W-1:0];
            REG_WINDOW_TO:    win_to   = val[CLOCK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input run_mode_t mode, input logic act, input logic idl,
                              input int unsigned on_s, input int unsigned off_s,
                              input int unsigned rep, input clock_t from, input clock_t to);
        write_reg(REG_RUN_MODE, mode);
        write_reg(REG_ACTIVE_LEVEL, act);
        write_reg(REG_IDLE_LEVEL, idl);
        write_reg(REG_ON_SECONDS, on_s);
        write_reg(REG_OFF_SECONDS, off_s);
        write_reg(REG_REPEAT_COUNT, rep);
        write_reg(REG_WINDOW_FROM, from);
        write_reg(REG_WINDOW_TO, to);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk); while (checked_total != queued_total);
        repeat (6) @(posedge aclk);
    endtask

    // A trigger followed by enough ticks to finish a one-second on phase and the
    // zero-length off phase behind it.
    task automatic timed_run(input int unsigned h, input int unsigned m);
        queue_item(mk(CMD_EVENT, h, m, act_lvl, act_lvl));
        repeat (1003) begin
            if ($urandom_range(0, 49) == 0) queue_item(mk(CMD_FORCE, h, m, 1'b0, 1'b0));
            queue_item(rand_item(100));
        end
        repeat (20) queue_item(rand_item(60));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Window always open and zero on-time: events make the relay follow the pin.
        set_config(MODE_DETECTOR, 1'b1, 1'b0, 0, 0, 0, hm(0, 0), WINDOW_TO_RESET);
        queue_item(mk(CMD_TICK, 0, 0, 1'b0, 1'b0));
        queue_item(mk(CMD_TICK, 23, 59, 1'b1, 1'b1));
        queue_item(mk(CMD_TICK, 31, 63, 1'b1, 1'b0));
        queue_item(mk(CMD_EVENT, 0, 0, 1'b1, 1'b1));
        queue_item(mk(CMD_EVENT, 23, 59, 1'b1, 1'b0));
        queue_item(mk(CMD_EVENT, 12, 30, 1'b0, 1'b1));
        queue_item(mk(CMD_FORCE, 5, 5, 1'b1, 1'b1));
        queue_item(mk(CMD_STOP, 6, 6, 1'b1, 1'b1));
        queue_item(mk(CMD_EVENT, 16, 32, 1'b1, 1'b1));
        queue_item(mk(CMD_TICK, 16, 32, 1'b0, 1'b0));
        queue_item(mk(CMD_EVENT, 31, 63, 1'b1, 1'b1));
        drain();

        // Largest timing values, inverted levels and a window across midnight.
        set_config(MODE_SCHED_DET, 1'b0, 1'b1, 65535, 65535, 65535, hm(23, 0), hm(1, 0));
        queue_item(mk(CMD_EVENT, 23, 30, 1'b0, 1'b0));
        queue_item(mk(CMD_TICK, 23, 31, 1'b0, 1'b0));
        queue_item(mk(CMD_EVENT, 12, 0, 1'b0, 1'b0));
        queue_item(mk(CMD_EVENT, 0, 59, 1'b0, 1'b1));
        queue_item(mk(CMD_FORCE, 0, 59, 1'b0, 1'b0));
        queue_item(mk(CMD_STOP, 1, 0, 1'b0, 1'b0));
        queue_item(mk(CMD_TICK, 1, 0, 1'b0, 1'b0));
        drain();

        set_config(MODE_SCHEDULE, 1'b1, 1'b0, 0, 0, 0, hm(22, 30), hm(6, 15));
        repeat (60) queue_item(rand_item(70));
        drain();

        set_config(MODE_SCHEDULE, 1'b0, 1'b1, 0, 0, 0, hm(8, 0), hm(17, 30));
        repeat (40) queue_item(rand_item(70));
        drain();

        // Two on phases per trigger: the zero-length off phase restarts the on phase.
        set_config(MODE_SCHED_DET, 1'b0, 1'b1, 1, 0, 2, hm(0, 0), WINDOW_TO_RESET);
        timed_run(12, 0);
        drain();

        set_config(MODE_DETECTOR, 1'b1, 1'b1, 65535, 65535, 65535, hm(10, 5), hm(10, 40));
        repeat (40) queue_item(rand_item(50));
        drain();

        // An inverted window within one hour is never open.
        set_config(MODE_SCHEDULE, 1'b0, 1'b0, 0, 65535, 0, hm(7, 40), hm(7, 10));
        repeat (30) queue_item(rand_item(50));
        drain();

        for (int k = 0; k < 8; k++) begin
            set_config(run_mode_t'(k % 4), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 3),
                       rand_clock(), rand_clock());
            repeat (30) queue_item(rand_item(55));
            drain();
        end

        if (faults == 0) begin
            $display("cyclic_relay_timer_with_time_window_top: match");
        end else begin
            $display("cyclic_relay_timer_with_time_window_top: mismatch");
        end
        $finish;
    end

endmodule
